FILE: sv/mldsa_ru_pkg.sv
`timescale 1ns / 1ps
package mldsa_ru_pkg;

    localparam int NSTAGE    = 6;
    localparam int DROP_BITS = 13;

    localparam logic [22:0] MODULUS = 23'd8380417;
    // (MODULUS-1)/2, the largest low part kept without reduction
    localparam logic signed [24:0] HALF_MOD = 25'sd4190208;

    localparam logic signed [23:0] GAMMA2_WIDE   = 24'sd261888;
    localparam logic signed [23:0] GAMMA2_NARROW = 24'sd95232;
    localparam logic [22:0] TWO_G_WIDE   = 23'd523776;
    localparam logic [22:0] TWO_G_NARROW = 23'd190464;

    localparam logic [23:0] EST_BIAS        = 24'd127;
    localparam logic [23:0] P2R_BIAS        = 24'd4095;
    localparam logic [13:0] EST_MUL_WIDE    = 14'd1025;
    localparam logic [13:0] EST_MUL_NARROW  = 14'd11275;
    localparam logic [30:0] EST_RND_WIDE    = 31'd2097152;
    localparam logic [30:0] EST_RND_NARROW  = 31'd8388608;
    localparam logic [5:0]  TOP_NARROW      = 6'd43;
    localparam logic [13:0] P2R_STEP        = 14'd8192;

    typedef enum logic [1:0] {
        KIND_POWER2ROUND = 2'd0,
        KIND_DECOMPOSE   = 2'd1,
        KIND_MAKE_HINT   = 2'd2,
        KIND_USE_HINT    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [NSTAGE-1:0] load;
    } t_pipe_ctrl;

    typedef struct packed {
        t_kind              kind;
        logic               mode;
        logic [22:0]        a;
        logic [5:0]         q;
        logic [9:0]         p2r_high;
        logic signed [13:0] p2r_low;
        logic               hint_out;
        logic               hint_in;
    } t_est_item;

endpackage

FILE: sv/mldsa_ru_ctrl.sv
`timescale 1ns / 1ps
module mldsa_ru_ctrl
    import mldsa_ru_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_pipe_ctrl o_ctrl
);

    logic [NSTAGE-1:0] r_valid;
    logic [NSTAGE:0]   n_ready;

    // a stage takes a new request when empty or when its occupant moves on
    always_comb begin
        n_ready[NSTAGE] = i_out_ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            n_ready[k] = !r_valid[k] || n_ready[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (n_ready[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (n_ready[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign o_ctrl.load = n_ready[NSTAGE-1:0];
    assign o_in_ready  = n_ready[0];
    assign o_out_valid = r_valid[NSTAGE-1];

endmodule

FILE: sv/mldsa_ru_est.sv
`timescale 1ns / 1ps
module mldsa_ru_est
    import mldsa_ru_pkg::*;
(
    input  logic               i_clk,
    input  t_pipe_ctrl         i_ctrl,
    input  t_kind              i_kind,
    input  logic               i_mode,
    input  logic [22:0]        i_coefficient,
    input  logic signed [23:0] i_low_in,
    input  logic [9:0]         i_high_in,
    input  logic               i_hint_in,
    output t_est_item          o_item
);

    // stage 1: reduced coefficient
    t_kind              r1_kind;
    logic               r1_mode;
    logic [22:0]        r1_a;
    logic signed [23:0] r1_low_in;
    logic [9:0]         r1_high_in;
    logic               r1_hint_in;
    logic [22:0]        n1_a;

    // stage 2: quotient estimate product, power2round high, hint test
    t_kind              r2_kind;
    logic               r2_mode;
    logic [22:0]        r2_a;
    logic [29:0]        r2_prod;
    logic [9:0]         r2_p2r_high;
    logic               r2_hint_out;
    logic               r2_hint_in;
    logic [23:0]        n2_est_sum;
    logic [23:0]        n2_p2r_sum;
    logic [15:0]        n2_t;
    logic [13:0]        n2_mul;
    logic [29:0]        n2_prod;
    logic signed [23:0] n2_g;
    logic               n2_hint;

    // stage 3: quotient
    t_est_item          r3_item;
    logic [30:0]        n3_sum;
    logic [6:0]         n3_top;
    logic [5:0]         n3_q;
    logic signed [13:0] n3_p2r_low;

    always_comb begin
        n1_a = (i_coefficient >= MODULUS) ? i_coefficient - MODULUS : i_coefficient;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[0]) begin
            r1_kind    <= i_kind;
            r1_mode    <= i_mode;
            r1_a       <= n1_a;
            r1_low_in  <= i_low_in;
            r1_high_in <= i_high_in;
            r1_hint_in <= i_hint_in;
        end
    end

    always_comb begin
        n2_est_sum = {1'b0, r1_a} + EST_BIAS;
        n2_t       = n2_est_sum[22:7];
        n2_mul     = r1_mode ? EST_MUL_NARROW : EST_MUL_WIDE;
        n2_prod    = 30'(n2_t) * 30'(n2_mul);
        n2_p2r_sum = {1'b0, r1_a} + P2R_BIAS;
        n2_g       = r1_mode ? GAMMA2_NARROW : GAMMA2_WIDE;
        n2_hint    = (r1_low_in > n2_g) || (r1_low_in < -n2_g)
                     || ((r1_low_in == -n2_g) && (r1_high_in != '0));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[1]) begin
            r2_kind     <= r1_kind;
            r2_mode     <= r1_mode;
            r2_a        <= r1_a;
            r2_prod     <= n2_prod;
            r2_p2r_high <= n2_p2r_sum[22:DROP_BITS];
            r2_hint_out <= n2_hint;
            r2_hint_in  <= r1_hint_in;
        end
    end

    always_comb begin
        n3_sum = {1'b0, r2_prod} + (r2_mode ? EST_RND_NARROW : EST_RND_WIDE);
        n3_top = n3_sum[30:24];
        if (r2_mode) begin
            // the top estimate wraps to zero
            n3_q = (n3_top > 7'(TOP_NARROW)) ? 6'd0 : n3_top[5:0];
        end else begin
            n3_q = {2'b00, n3_sum[25:22]};
        end
        // the rounded high part exceeds the upper bits by at most one step
        if (r2_p2r_high == r2_a[22:DROP_BITS]) begin
            n3_p2r_low = signed'({1'b0, r2_a[DROP_BITS-1:0]});
        end else begin
            n3_p2r_low = signed'({1'b0, r2_a[DROP_BITS-1:0]} - P2R_STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[2]) begin
            r3_item.kind     <= r2_kind;
            r3_item.mode     <= r2_mode;
            r3_item.a        <= r2_a;
            r3_item.q        <= n3_q;
            r3_item.p2r_high <= r2_p2r_high;
            r3_item.p2r_low  <= n3_p2r_low;
            r3_item.hint_out <= r2_hint_out;
            r3_item.hint_in  <= r2_hint_in;
        end
    end

    assign o_item = r3_item;

endmodule

FILE: sv/mldsa_ru_low.sv
`timescale 1ns / 1ps
module mldsa_ru_low
    import mldsa_ru_pkg::*;
(
    input  logic               i_clk,
    input  t_pipe_ctrl         i_ctrl,
    input  t_est_item          i_item,
    output logic [9:0]         o_high_part,
    output logic signed [18:0] o_low_part,
    output logic               o_hint_out
);

    // stage 4: multiple of 2*gamma2
    t_est_item          r4_item;
    logic [22:0]        r4_m;
    logic [22:0]        n4_m;

    // stage 5: low part
    t_est_item          r5_item;
    logic signed [18:0] r5_lo;
    logic signed [24:0] n5_diff;
    logic signed [24:0] n5_lo;

    // stage 6: result
    logic [9:0]         r6_high;
    logic signed [18:0] r6_low;
    logic               r6_hint;
    logic [5:0]         n6_adj;
    logic [3:0]         n6_adj_wide;
    logic               n6_up;

    always_comb begin
        n4_m = 23'(i_item.q) * (i_item.mode ? TWO_G_NARROW : TWO_G_WIDE);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[3]) begin
            r4_item <= i_item;
            r4_m    <= n4_m;
        end
    end

    always_comb begin
        n5_diff = signed'({2'b00, r4_item.a}) - signed'({2'b00, r4_m});
        // fold a low part above (MODULUS-1)/2 down by the modulus
        if (n5_diff > HALF_MOD) begin
            n5_lo = n5_diff - signed'({2'b00, MODULUS});
        end else begin
            n5_lo = n5_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[4]) begin
            r5_item <= r4_item;
            r5_lo   <= n5_lo[18:0];
        end
    end

    always_comb begin
        n6_up = (r5_lo > 19'sd0);
        n6_adj_wide = n6_up ? r5_item.q[3:0] + 4'd1 : r5_item.q[3:0] - 4'd1;
        if (!r5_item.hint_in) begin
            n6_adj = r5_item.q;
        end else if (!r5_item.mode) begin
            n6_adj = {2'b00, n6_adj_wide};
        end else if (n6_up) begin
            n6_adj = (r5_item.q == TOP_NARROW) ? 6'd0 : r5_item.q + 6'd1;
        end else begin
            n6_adj = (r5_item.q == 6'd0) ? TOP_NARROW : r5_item.q - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[5]) begin
            case (r5_item.kind)
                KIND_POWER2ROUND: begin
                    r6_high <= r5_item.p2r_high;
                    r6_low  <= 19'(r5_item.p2r_low);
                    r6_hint <= 1'b0;
                end
                KIND_DECOMPOSE: begin
                    r6_high <= 10'(r5_item.q);
                    r6_low  <= r5_lo;
                    r6_hint <= 1'b0;
                end
                KIND_MAKE_HINT: begin
                    r6_high <= '0;
                    r6_low  <= '0;
                    r6_hint <= r5_item.hint_out;
                end
                default: begin
                    r6_high <= 10'(n6_adj);
                    r6_low  <= '0;
                    r6_hint <= 1'b0;
                end
            endcase
        end
    end

    assign o_high_part = r6_high;
    assign o_low_part  = r6_low;
    assign o_hint_out  = r6_hint;

endmodule

FILE: sv/ml_dsa_rounding_unit.sv
`timescale 1ns / 1ps
// ML-DSA rounding unit: power2round, decompose, make hint and use hint on one
// coefficient per request, chosen by s_axis_tuser. The datapath is a six-stage
// pipeline (reduce, estimate multiply, quotient, 2*gamma2 multiply, low part,
// hint adjust and result select) with a valid bit per stage, so it takes one
// request every cycle while the output is not stalled; a stalled output holds
// only the stages that are full, and empty stages keep filling. gamma2_mode is
// to be written through the cfg channel only while no request is in flight (the
// block itself does not enforce this) and applies to every request accepted after it.
module ml_dsa_rounding_unit
    import mldsa_ru_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,     // gamma2_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // coefficient[22:0], low_in[46:23], high_in[56:47],
                                        // hint_in[57], zero[63:58]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // high_part[9:0], low_part[28:10], hint_out[29],
                                        // zero[31:30]
);

    logic               r_gamma2_mode;
    t_pipe_ctrl         w_ctrl;
    t_est_item          w_item;
    logic [9:0]         w_high_part;
    logic signed [18:0] w_low_part;
    logic               w_hint_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma2_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_gamma2_mode <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    mldsa_ru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctrl      (w_ctrl)
    );

    mldsa_ru_est u_est (
        .i_clk         (i_clk),
        .i_ctrl        (w_ctrl),
        .i_kind        (t_kind'(s_axis_tuser)),
        .i_mode        (r_gamma2_mode),
        .i_coefficient (s_axis_tdata[22:0]),
        .i_low_in      (signed'(s_axis_tdata[46:23])),
        .i_high_in     (s_axis_tdata[56:47]),
        .i_hint_in     (s_axis_tdata[57]),
        .o_item        (w_item)
    );

    mldsa_ru_low u_low (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_item      (w_item),
        .o_high_part (w_high_part),
        .o_low_part  (w_low_part),
        .o_hint_out  (w_hint_out)
    );

    assign m_axis_tdata = {2'b00, w_hint_out, w_low_part, w_high_part};

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
    import mldsa_ru_pkg::*;

    localparam int Q_MOD         = 8380417;
    localparam int GAMMA_WIDE    = 261888;
    localparam int GAMMA_NARROW  = 95232;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 90;
    localparam int PHASE_ITEMS   = 150;
    localparam bit [0:3] PHASE_MODE = 4'b1001;

    typedef struct {
        t_kind        kind;
        logic         mode;
        logic [22:0]  coef;
        logic [23:0]  lo_in;
        logic [9:0]   hi_in;
        logic         hint;
        logic         typed;
        int           exp_high;
        int           exp_low;
        logic         exp_hint;
    } coeff_req_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // coefficient[22:0], low_in[46:23], high_in[56:47],
                                 // hint_in[57], zero[63:58]
    logic [1:0]  s_axis_tuser;   // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // high_part[9:0], low_part[28:10], hint_out[29],
                                 // zero[31:30]

    logic [31:0] due_roundings[$];
    coeff_req_t  plan[$];
    coeff_req_t  cur_req;
    logic        mode_now;
    logic        calm;
    int          holds_asked;
    int          holds_served;
    int          hold_left;
    int          faults;
    int          n_sent;
    int          n_checked;
    int          n_writes;
    int          stall_cycles;

    ml_dsa_rounding_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] pack_result(int high, int low, logic hint);
        return {2'b00, hint, low[18:0], high[9:0]};
    endfunction

    // Expected result word for one request under the given gamma2 mode
    function automatic logic [31:0] round_coeff(t_kind kind, logic [22:0] coef,
                                                logic signed [23:0] lo_in,
                                                logic [9:0] hi_in, logic hint,
                                                logic mode);
        longint a, g, q, dlo, high, low, lin;
        logic   flag;
        a = coef;
        if (a >= Q_MOD)
            a -= Q_MOD;
        g = mode ? GAMMA_NARROW : GAMMA_WIDE;
        // quotient estimate by multiply and shift, as the hardware does it
        q = (a + 127) >>> 7;
        if (!mode) begin
            q = ((q * 1025 + (longint'(1) << 21)) >>> 22) & 15;
        end else begin
            q = (q * 11275 + (longint'(1) << 23)) >>> 24;
            if (q > 43)
                q = 0;
        end
        dlo = a - q * 2 * g;
        if (dlo > (Q_MOD - 1) / 2)
            dlo -= Q_MOD;
        high = 0;
        low  = 0;
        flag = 1'b0;
        case (kind)
            KIND_POWER2ROUND: begin
                high = (a + 4095) >>> DROP_BITS;
                low  = a - high * 8192;
            end
            KIND_DECOMPOSE: begin
                high = q;
                low  = dlo;
            end
            KIND_MAKE_HINT: begin
                lin  = lo_in;
                flag = (lin > g) || (lin < -g) || (lin == -g && hi_in != 0);
            end
            default: begin
                high = q;
                if (hint) begin
                    // a zero low part steps down
                    if (!mode)
                        high = (dlo > 0) ? ((q + 1) & 15) : ((q + 15) & 15);
                    else if (dlo > 0)
                        high = (q == 43) ? 0 : q + 1;
                    else
                        high = (q == 0) ? 43 : q - 1;
                end
            end
        endcase
        return {2'b00, flag, low[18:0], high[9:0]};
    endfunction

    task automatic add_row(t_kind kind, logic mode, int coef, int lo_in, int hi_in,
                           logic hint, logic typed, int eh, int el, logic ef);
        coeff_req_t r;
        r.kind     = kind;
        r.mode     = mode;
        r.coef     = coef[22:0];
        r.lo_in    = lo_in[23:0];
        r.hi_in    = hi_in[9:0];
        r.hint     = hint;
        r.typed    = typed;
        r.exp_high = eh;
        r.exp_low  = el;
        r.exp_hint = ef;
        plan.push_back(r);
    endtask

    function automatic coeff_req_t draw_req();
        coeff_req_t r;
        int c, g, v;
        g = mode_now ? GAMMA_NARROW : GAMMA_WIDE;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: c = $urandom_range(Q_MOD - 1);
            // near a multiple of 2*gamma2, including the top wrap
            5, 6, 7: c = $urandom_range(mode_now ? 44 : 16) * 2 * g + $urandom_range(8) - 4;
            // near a power2round rounding edge
            8: c = $urandom_range(1023) * 8192 + $urandom_range(4098, 4094);
            default: c = $urandom_range(8388607, Q_MOD);
        endcase
        if (c < 0)
            c += Q_MOD;
        if (c > 8388607)
            c -= Q_MOD;
        if ($urandom_range(3) == 0) begin
            v = $urandom;
        end else begin
            v = ($urandom_range(1) ? GAMMA_NARROW : GAMMA_WIDE) + $urandom_range(2) - 1;
            if ($urandom_range(1))
                v = -v;
        end
        r.kind     = t_kind'($urandom_range(3));
        r.mode     = mode_now;
        r.coef     = c[22:0];
        r.lo_in    = v[23:0];
        r.hi_in    = ($urandom_range(3) == 0) ? 10'd0 : 10'($urandom_range(1023));
        r.hint     = $urandom_range(1);
        r.typed    = 1'b0;
        r.exp_high = 0;
        r.exp_low  = 0;
        r.exp_hint = 1'b0;
        return r;
    endfunction

    task automatic set_mode(logic v);
        while (due_roundings.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        mode_now = v;
        n_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic offer_coeff(coeff_req_t r);
        int gap;
        // outside the calm stretch, about 15 in 100 requests are preceded by a random idle gap
        if (!calm && $urandom_range(99) < 15) begin
            gap = $urandom_range(4, 1);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cur_req       = r;
        s_axis_tuser  = r.kind;
        s_axis_tdata  = {6'd0, r.hint, r.hi_in, r.lo_in, r.coef};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic note_fault(string what, int want, int got);
        faults++;
        if (faults <= 10)
            $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    endtask

    // Receiver: random back-pressure, a calm stretch, and one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        holds_served  = 0;
        hold_left     = 0;
        forever begin
            @(negedge i_clk);
            if (holds_asked != holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else if (calm) begin
                m_axis_tready = 1'b1;
            end else begin
                m_axis_tready = ($urandom_range(99) >= 27);
            end
        end
    end

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (cur_req.typed)
                    due_roundings.push_back(pack_result(cur_req.exp_high, cur_req.exp_low,
                                                        cur_req.exp_hint));
                else
                    due_roundings.push_back(round_coeff(t_kind'(s_axis_tuser),
                                                        s_axis_tdata[22:0],
                                                        s_axis_tdata[46:23],
                                                        s_axis_tdata[56:47],
                                                        s_axis_tdata[57], mode_now));
                n_sent++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_roundings.size() == 0) begin
                    note_fault("result with nothing pending", 0, m_axis_tdata);
                end else begin
                    want = due_roundings.pop_front();
                    n_checked++;
                    if (want[9:0] != m_axis_tdata[9:0])
                        note_fault("high_part", want[9:0], m_axis_tdata[9:0]);
                    if (want[28:10] != m_axis_tdata[28:10])
                        note_fault("low_part", $signed(want[28:10]),
                                   $signed(m_axis_tdata[28:10]));
                    if (want[29] != m_axis_tdata[29])
                        note_fault("hint_out", want[29], m_axis_tdata[29]);
                end
            end
        end
    end

    // Watchdog: abandon the run when no channel has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles == STALL_LIMIT) begin
            $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_POWER2ROUND;
        mode_now      = 1'b0;
        calm          = 1'b0;
        holds_asked   = 0;
        faults        = 0;
        n_sent        = 0;
        n_checked     = 0;
        n_writes      = 0;
        stall_cycles  = 0;
        cur_req       = '{kind: KIND_POWER2ROUND, default: 0};

        // reset value of gamma2_mode is used first, without a write
        add_row(KIND_POWER2ROUND, 0, 0,       0, 0, 0, 1, 0,    0,     0);
        add_row(KIND_POWER2ROUND, 0, 8380416, 0, 0, 0, 1, 1023, 0,     0);
        add_row(KIND_POWER2ROUND, 0, 4096,    0, 0, 0, 1, 0,    4096,  0);
        add_row(KIND_POWER2ROUND, 0, 4097,    0, 0, 0, 1, 1,    -4095, 0);
        add_row(KIND_POWER2ROUND, 0, 8388607, 0, 0, 0, 1, 1,    -2,    0);
        add_row(KIND_DECOMPOSE,   0, 0,       0, 0, 0, 1, 0,    0,     0);
        add_row(KIND_DECOMPOSE,   0, 8380416, 0, 0, 0, 1, 0,    -1,    0);
        add_row(KIND_DECOMPOSE,   0, Q_MOD,   0, 0, 0, 1, 0,    0,     0);
        add_row(KIND_DECOMPOSE,   0, 261888,  0, 0, 0, 0, 0,    0,     0);
        add_row(KIND_MAKE_HINT,   0, 0, 0,        0,    0, 1, 0, 0, 0);
        add_row(KIND_MAKE_HINT,   0, 0, 261888,   0,    0, 1, 0, 0, 0);
        add_row(KIND_MAKE_HINT,   0, 0, 261889,   0,    0, 1, 0, 0, 1);
        add_row(KIND_MAKE_HINT,   0, 0, -261888,  0,    0, 1, 0, 0, 0);
        add_row(KIND_MAKE_HINT,   0, 0, -261888,  1023, 0, 1, 0, 0, 1);
        add_row(KIND_MAKE_HINT,   0, 0, -261889,  0,    0, 1, 0, 0, 1);
        add_row(KIND_MAKE_HINT,   0, 0, 8388607,  0,    0, 1, 0, 0, 1);
        add_row(KIND_MAKE_HINT,   0, 0, -8388608, 0,    0, 1, 0, 0, 1);
        add_row(KIND_USE_HINT,    0, 0,       0, 0, 1, 1, 15, 0, 0);
        add_row(KIND_USE_HINT,    0, 8380416, 0, 0, 1, 1, 15, 0, 0);
        add_row(KIND_USE_HINT,    0, 523776,  0, 0, 1, 0, 0,  0, 0);
        add_row(KIND_DECOMPOSE,   1, 8380416, 0, 0, 0, 1, 0,  -1, 0);
        add_row(KIND_MAKE_HINT,   1, 0, 95232,  0, 0, 1, 0, 0, 0);
        add_row(KIND_MAKE_HINT,   1, 0, 95233,  0, 0, 1, 0, 0, 1);
        add_row(KIND_MAKE_HINT,   1, 0, -95232, 7, 0, 1, 0, 0, 1);
        add_row(KIND_USE_HINT,    1, 0,       0, 0, 1, 1, 43, 0, 0);
        add_row(KIND_USE_HINT,    1, 43 * 190464 + 1000, 0, 0, 1, 0, 0, 0, 0);

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[k]) begin
            if (plan[k].mode != mode_now) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                set_mode(plan[k].mode);
            end
            offer_coeff(plan[k]);
        end

        for (int p = 0; p < 4; p++) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            set_mode(PHASE_MODE[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                calm = (p == 1 && i >= 30 && i < 100);
                if (p == 2 && i == 40)
                    holds_asked++;
                offer_coeff(draw_req());
            end
        end
        calm = 1'b0;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;

        while (due_roundings.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (due_roundings.size() != 0)
            note_fault("results never delivered", due_roundings.size(), 0);

        $display("Sent %0d requests (%0d directed), checked %0d results, %0d gamma2 writes",
                 n_sent, plan.size(), n_checked, n_writes);
        $display("All four kinds in both gamma2 modes, with a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (faults == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
